// ===== rtl/period_capture_mean_volume_assert.svh =====
// assertion macros used by the checker file of the period capture block
// expects a signal named aclk in the scope of each use, and aresetn for PCMV_ASSERT
`ifndef PERIOD_CAPTURE_MEAN_VOLUME_ASSERT_SVH
`define PERIOD_CAPTURE_MEAN_VOLUME_ASSERT_SVH

// checked only while out of reset
`define PCMV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define PCMV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/pcmv_pkg.sv =====
// shared types and constants of the period capture mean volume block
// no dependencies
package pcmv_pkg;

    localparam int TIMER_BITS          = 16;
    localparam int DOUBLE_PERIOD_LIMIT = 4000;
    localparam int SCALE_SHIFT         = 8;

    localparam int OP_W      = 2;
    localparam int CAP_W     = TIMER_BITS;
    localparam int TUNE_W    = 24;
    localparam int NUM_W     = 31;
    localparam int DOFF_W    = 24;
    localparam int VOFF_W    = 17;
    localparam int VOL_W     = 11;
    localparam int MEAN_W    = 32;
    localparam int CNT_W     = 8;
    localparam int SUM_W     = 31;
    localparam int DIFF_W    = CAP_W + SCALE_SHIFT + 3;
    localparam int OFFP_W    = CNT_W + DOFF_W;
    localparam int DIVD_W    = NUM_W + CNT_W;
    localparam int DIVS_W    = OFFP_W + 2;
    localparam int DIV_CNT_W = $clog2(DIVD_W + 1);
    localparam int VDIF_W    = DIVD_W + 2;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 31;

    localparam int S_TDATA_W = 16;
    localparam int OUT_W     = VOL_W + MEAN_W + CNT_W;
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [VOL_W-1:0] VOL_MAX = VOL_W'(1024);
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_ACTIVATE  = 2'd0,
        OP_CAPTURE   = 2'd1,
        OP_CALCULATE = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TUNED_OFFSET     = 2'd0,
        REG_VOLUME_NUMERATOR = 2'd1,
        REG_DIVISOR_OFFSET   = 2'd2,
        REG_VOLUME_OFFSET    = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ACC,
        S_MUL_NUM,
        S_MUL_OFF,
        S_MEAN_START,
        S_MEAN_WAIT,
        S_VOL_START,
        S_VOL_WAIT,
        S_VOL,
        S_OUT
    } state_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_res_t;

endpackage

// ===== rtl/pcmv_div.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on pcmv_pkg
module pcmv_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [pcmv_pkg::DIVD_W-1:0]    dividend,
    input  logic [pcmv_pkg::DIVS_W-1:0]    divisor,
    output pcmv_pkg::div_res_t             res
);
    import pcmv_pkg::*;

    logic [DIVD_W-1:0]    quo_reg, quo_next;
    logic [DIVS_W-1:0]    rem_reg, rem_next;
    logic [DIVS_W-1:0]    dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DIVS_W:0] trial;
    logic [DIVS_W:0] trial_sub;
    logic            fits;

    assign trial     = {rem_reg, quo_reg[DIVD_W-1]};
    assign trial_sub = trial - {1'b0, dsr_reg};
    assign fits      = trial >= {1'b0, dsr_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            step_next = DIV_CNT_W'(DIVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the top trial bit drops out
            rem_next  = fits ? trial_sub[DIVS_W-1:0] : trial[DIVS_W-1:0];
            quo_next  = {quo_reg[DIVD_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign res.done     = done_reg;
    assign res.quotient = quo_reg;

endmodule

// ===== rtl/period_capture_mean_volume.sv =====
// top level of the period capture mean volume block, one oscillator channel
// depends on pcmv_pkg and pcmv_div
//
// Each input item is one timer event for one oscillator: activate latches the
// capture value and restarts the period count, capture adds the offset-corrected
// scaled period (256 * timer delta minus the tuned offset, twice the offset and
// two counts for a long period) to a saturating window sum when it is positive,
// and calculate turns a nonzero window into a mean period and a clamped 0..1024
// volume, then clears it. Every item returns exactly one result item with the
// held volume, the held mean and the current period count. The block takes one
// item at a time and drops s_tready while it works. A full calculate makes two
// 39-step passes through the one shared restoring divider (mean = sum / count,
// then numerator * count / divisor).
// The result sits in an output register, so the next item can be accepted while
// it waits for m_tready. Configuration must be written only while no item is in
// flight; the sequencer does not hold writes back.
module period_capture_mean_volume (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pcmv_pkg::S_TDATA_W-1:0]     s_tdata,   // [15:0] capture_value
    input  logic [pcmv_pkg::OP_W-1:0]          s_tuser,   // [1:0] op
    // result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [10:0] volume, [42:11] mean_period, [50:43] period_count, rest zero
    output logic [pcmv_pkg::M_TDATA_W-1:0]     m_tdata,
    // configuration writes
    input  logic                               cfg_we,
    input  logic [pcmv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pcmv_pkg::CFG_W-1:0]         cfg_data
);
    import pcmv_pkg::*;

    // configuration registers
    logic [TUNE_W-1:0]        tuned_offset_reg;
    logic [NUM_W-1:0]         volume_numerator_reg;
    logic [DOFF_W-1:0]        divisor_offset_reg;
    logic signed [VOFF_W-1:0] volume_offset_reg;

    // sequencer and item registers
    state_t                   state_reg, state_next;
    op_t                      op_reg, op_next;
    logic [CAP_W-1:0]         cap_reg, cap_next;

    // channel state
    logic [CAP_W-1:0]         last_capture_reg, last_capture_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [MEAN_W-1:0]        mean_reg, mean_next;
    logic [VOL_W-1:0]         volume_reg, volume_next;

    // working registers
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic [DIVD_W-1:0]        num_prod_reg, num_prod_next;
    logic [OFFP_W-1:0]        off_prod_reg, off_prod_next;
    logic [DIVS_W-1:0]        divisor_reg, divisor_next;
    logic [DIVD_W-1:0]        q_reg, q_next;

    // output register
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]     m_tdata_reg, m_tdata_next;

    // shared divider hookup
    logic                     div_start;
    logic [DIVD_W-1:0]        div_dividend;
    logic [DIVS_W-1:0]        div_divisor;
    div_res_t                 div_res;

    // capture datapath
    logic [CAP_W-1:0]         period;
    logic                     is_double;
    logic signed [DIFF_W-1:0] scaled;
    logic signed [DIFF_W-1:0] off_ext;
    logic signed [DIFF_W-1:0] diff_calc;
    logic [CNT_W:0]           cnt_sum;
    logic [CNT_W-1:0]         cnt_inc;
    logic [SUM_W:0]           acc_sum;
    logic [SUM_W-1:0]         acc_sat;

    // volume clamp
    logic signed [VDIF_W-1:0] vol_diff;
    logic [VOL_W-1:0]         vol_clamped;

    // config writes, expected only while idle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tuned_offset_reg     <= '0;
            volume_numerator_reg <= '0;
            divisor_offset_reg   <= '0;
            volume_offset_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                REG_TUNED_OFFSET:     tuned_offset_reg     <= cfg_data[TUNE_W-1:0];
                REG_VOLUME_NUMERATOR: volume_numerator_reg <= cfg_data[NUM_W-1:0];
                REG_DIVISOR_OFFSET:   divisor_offset_reg   <= cfg_data[DOFF_W-1:0];
                REG_VOLUME_OFFSET:    volume_offset_reg    <= $signed(cfg_data[VOFF_W-1:0]);
                default: ;
            endcase
        end
    end

    // wrapped timer delta and the scaled, offset-corrected period
    assign period    = cap_reg - last_capture_reg;
    assign is_double = period > CAP_W'(DOUBLE_PERIOD_LIMIT);
    assign scaled    = $signed({3'b000, period, SCALE_SHIFT'(0)});
    assign off_ext   = $signed(DIFF_W'(tuned_offset_reg));
    assign diff_calc = scaled - off_ext - (is_double ? off_ext : DIFF_W'(0));

    // period count saturates, a long period counts twice
    assign cnt_sum = {1'b0, count_reg} + (is_double ? (CNT_W+1)'(2) : (CNT_W+1)'(1));
    assign cnt_inc = (cnt_sum > {1'b0, CNT_MAX}) ? CNT_MAX : cnt_sum[CNT_W-1:0];

    // only positive diffs reach here; sum saturates at the signed 32-bit max
    assign acc_sum = {1'b0, sum_reg} + (SUM_W+1)'(diff_reg[DIFF_W-2:0]);
    assign acc_sat = acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];

    // quotient minus volume offset, clamped to 0..1024
    assign vol_diff = $signed({2'b00, q_reg}) - VDIF_W'(volume_offset_reg);
    always_comb begin
        if (vol_diff < 0) begin
            vol_clamped = '0;
        end else if (vol_diff > $signed(VDIF_W'(VOL_MAX))) begin
            vol_clamped = VOL_MAX;
        end else begin
            vol_clamped = vol_diff[VOL_W-1:0];
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // sequencer
    always_comb begin
        state_next        = state_reg;
        op_next           = op_reg;
        cap_next          = cap_reg;
        last_capture_next = last_capture_reg;
        sum_next          = sum_reg;
        count_next        = count_reg;
        mean_next         = mean_reg;
        volume_next       = volume_reg;
        diff_next         = diff_reg;
        num_prod_next     = num_prod_reg;
        off_prod_next     = off_prod_reg;
        divisor_next      = divisor_reg;
        q_next            = q_reg;
        m_tvalid_next     = m_tvalid_reg;
        m_tdata_next      = m_tdata_reg;
        div_start         = 1'b0;
        div_dividend      = DIVD_W'(sum_reg);
        div_divisor       = DIVS_W'(count_reg);

        // result taken downstream frees the output register
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = op_t'(s_tuser);
                    cap_next   = s_tdata[CAP_W-1:0];
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (op_reg)
                    OP_ACTIVATE: begin
                        // sum is kept on purpose, only the count restarts
                        last_capture_next = cap_reg;
                        count_next        = '0;
                        state_next        = S_OUT;
                    end
                    OP_CAPTURE: begin
                        last_capture_next = cap_reg;
                        if (period == '0) begin
                            state_next = S_OUT;
                        end else begin
                            count_next = cnt_inc;
                            diff_next  = diff_calc;
                            state_next = S_ACC;
                        end
                    end
                    OP_CALCULATE: begin
                        if (sum_reg == '0) begin
                            state_next = S_OUT;
                        end else if (count_reg == '0) begin
                            // leftover sum after activate: zero mean and quotient
                            mean_next  = '0;
                            q_next     = '0;
                            state_next = S_VOL;
                        end else begin
                            state_next = S_MUL_NUM;
                        end
                    end
                    default: begin
                        // unused opcode, just report the held values
                        state_next = S_OUT;
                    end
                endcase
            end
            S_ACC: begin
                if (!diff_reg[DIFF_W-1] && (diff_reg != '0)) begin
                    sum_next = acc_sat;
                end
                state_next = S_OUT;
            end
            S_MUL_NUM: begin
                num_prod_next = DIVD_W'(volume_numerator_reg) * DIVD_W'(count_reg);
                state_next    = S_MUL_OFF;
            end
            S_MUL_OFF: begin
                off_prod_next = OFFP_W'(divisor_offset_reg) * OFFP_W'(count_reg);
                state_next    = S_MEAN_START;
            end
            S_MEAN_START: begin
                // divisor is always positive here since the sum is nonzero
                div_start    = 1'b1;
                div_dividend = DIVD_W'(sum_reg);
                div_divisor  = DIVS_W'(count_reg);
                divisor_next = DIVS_W'(sum_reg) + DIVS_W'(off_prod_reg);
                state_next   = S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
                if (div_res.done) begin
                    mean_next  = MEAN_W'(div_res.quotient[SUM_W-1:0]);
                    state_next = S_VOL_START;
                end
            end
            S_VOL_START: begin
                div_start    = 1'b1;
                div_dividend = num_prod_reg;
                div_divisor  = divisor_reg;
                state_next   = S_VOL_WAIT;
            end
            S_VOL_WAIT: begin
                if (div_res.done) begin
                    q_next     = div_res.quotient;
                    state_next = S_VOL;
                end
            end
            S_VOL: begin
                volume_next = vol_clamped;
                sum_next    = '0;
                count_next  = '0;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({count_reg, mean_reg, volume_reg});
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            last_capture_reg <= '0;
            sum_reg          <= '0;
            count_reg        <= '0;
            mean_reg         <= '0;
            volume_reg       <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            last_capture_reg <= last_capture_next;
            sum_reg          <= sum_next;
            count_reg        <= count_next;
            mean_reg         <= mean_next;
            volume_reg       <= volume_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
        op_reg       <= op_next;
        cap_reg      <= cap_next;
        diff_reg     <= diff_next;
        num_prod_reg <= num_prod_next;
        off_prod_reg <= off_prod_next;
        divisor_reg  <= divisor_next;
        q_reg        <= q_next;
        m_tdata_reg  <= m_tdata_next;
    end

    pcmv_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .res      (div_res)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/pcmv_checker.sv =====
// port-level checks for the period capture mean volume block, bound to the top
// depends on pcmv_pkg and period_capture_mean_volume_assert.svh
module pcmv_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [pcmv_pkg::M_TDATA_W-1:0]     m_tdata
);
    import pcmv_pkg::*;
    `include "period_capture_mean_volume_assert.svh"

    // stalled result holds
    `PCMV_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result moved")

    // one item at a time: busy right after an accept
    `PCMV_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "item accepted while busy")

    // volume never leaves its clamp range
    `PCMV_ASSERT(a_volume_range, m_tvalid |-> m_tdata[VOL_W-1:0] <= VOL_MAX, "volume above 1024")

    // reset empties the output register
    `PCMV_ASSERT_ALWAYS(a_reset_out, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind period_capture_mean_volume pcmv_checker u_pcmv_checker (.*);

// ===== tb/sv/tb_period_capture_mean_volume.sv =====
// self-checking testbench of the period capture mean volume block
// depends on pcmv_pkg and the period_capture_mean_volume rtl; a class tracks the
// window state and holds the readings still due, plain tasks drive the streams
module tb_period_capture_mean_volume;
    import pcmv_pkg::*;

    // tracker arithmetic limits
    localparam int                PERIOD_SPLIT = 4000;       // longer periods count twice
    localparam longint            SUM_CEIL     = 64'd2147483647;
    localparam longint            VOLUME_CEIL  = 1024;
    // opcode the block leaves unused
    localparam logic [OP_W-1:0]   OP_SPARE     = 2'd3;

    // run shape
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 150;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 1_000_000;

    // one expected reading, with the fields of m_tdata from the top in reverse bit order
    typedef struct packed {
        logic [VOL_W-1:0]  volume;
        logic [MEAN_W-1:0] mean_period;
        logic [CNT_W-1:0]  period_count;
    } reading_t;

    // window tracker: register copies, window state and the readings still due
    class period_window_tracker;
        logic [TUNE_W-1:0]        tune_ofs = '0;
        logic [NUM_W-1:0]         vol_num  = '0;
        logic [DOFF_W-1:0]        div_ofs  = '0;
        logic signed [VOFF_W-1:0] vol_ofs  = '0;

        logic [CAP_W-1:0]         last_cap  = '0;
        longint                   win_sum   = 0;
        logic [CNT_W-1:0]         win_count = '0;
        logic [MEAN_W-1:0]        mean_hold = '0;
        logic [VOL_W-1:0]         vol_hold  = '0;

        reading_t                 pending[$];
        int                       errors = 0;

        function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_TUNED_OFFSET:     tune_ofs = value[TUNE_W-1:0];
                REG_VOLUME_NUMERATOR: vol_num  = value[NUM_W-1:0];
                REG_DIVISOR_OFFSET:   div_ofs  = value[DOFF_W-1:0];
                REG_VOLUME_OFFSET:    vol_ofs  = value[VOFF_W-1:0];
                default: ;
            endcase
        endfunction

        // count saturates at all ones
        function void bump_count();
            if (win_count != '1) begin
                win_count++;
            end
        endfunction

        function void take_capture(logic [CAP_W-1:0] cap);
            logic [CAP_W-1:0] period;
            longint           delta;
            period   = cap - last_cap;   // wraps at the timer width
            last_cap = cap;
            if (period == '0) begin
                return;
            end
            delta = longint'(period) * 256 - longint'(tune_ofs);
            bump_count();
            if (period > PERIOD_SPLIT) begin
                bump_count();
                delta = delta - longint'(tune_ofs);
            end
            // only positive corrections reach the sum, which saturates
            if (delta > 0) begin
                win_sum = win_sum + delta;
                if (win_sum > SUM_CEIL) begin
                    win_sum = SUM_CEIL;
                end
            end
        endfunction

        function void close_window();
            longint divisor;
            longint quot;
            longint vol;
            if (win_sum <= 0) begin
                return;
            end
            divisor = win_sum + longint'(win_count) * longint'(div_ofs);
            quot    = 0;
            // a sum left over after activate with no new period: mean is zero
            if (win_count == '0) begin
                mean_hold = '0;
            end else begin
                mean_hold = MEAN_W'(win_sum / longint'(win_count));
                if (divisor > 0) begin
                    quot = (longint'(vol_num) * longint'(win_count)) / divisor;
                end
            end
            if (divisor <= 0) begin
                vol = VOLUME_CEIL;
            end else begin
                vol = quot - longint'(vol_ofs);
            end
            if (vol < 0) begin
                vol = 0;
            end
            if (vol > VOLUME_CEIL) begin
                vol = VOLUME_CEIL;
            end
            vol_hold  = VOL_W'(vol);
            win_sum   = 0;
            win_count = '0;
        endfunction

        // accepted input item: advance the state and queue the reading it yields
        function void note_event(logic [OP_W-1:0] op, logic [CAP_W-1:0] cap);
            reading_t r;
            case (op)
                OP_ACTIVATE: begin
                    last_cap  = cap;
                    win_count = '0;   // the sum is kept on purpose
                end
                OP_CAPTURE:   take_capture(cap);
                OP_CALCULATE: close_window();
                default: ;            // spare opcode only returns the held values
            endcase
            r.volume       = vol_hold;
            r.mean_period  = mean_hold;
            r.period_count = win_count;
            pending.push_back(r);
        endfunction

        // accepted result item: compare with the oldest reading due
        function void check_reading(logic [M_TDATA_W-1:0] data);
            reading_t         want;
            logic [VOL_W-1:0]  got_vol;
            logic [MEAN_W-1:0] got_mean;
            logic [CNT_W-1:0]  got_cnt;
            if (pending.size() == 0) begin
                $display("%0t: result item with no item pending, m_tdata %h", $time, data);
                errors++;
                return;
            end
            want     = pending.pop_front();
            got_vol  = data[VOL_W-1:0];
            got_mean = data[VOL_W +: MEAN_W];
            got_cnt  = data[VOL_W+MEAN_W +: CNT_W];
            if (got_vol !== want.volume) begin
                $display("%0t: volume mismatch, expected %0d, actual %0d",
                         $time, want.volume, got_vol);
                errors++;
            end
            if (got_mean !== want.mean_period) begin
                $display("%0t: mean_period mismatch, expected %0d, actual %0d",
                         $time, $signed(want.mean_period), $signed(got_mean));
                errors++;
            end
            if (got_cnt !== want.period_count) begin
                $display("%0t: period_count mismatch, expected %0d, actual %0d",
                         $time, want.period_count, got_cnt);
                errors++;
            end
        endfunction
    endclass

    // clock, reset and the block's ports
    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;     // [15:0] capture_value
    logic [OP_W-1:0]        s_tuser;     // [1:0] op
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;     // [10:0] volume, [42:11] mean_period, [50:43] period_count
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    // idle rates of both sides in percent, changed per phase
    int                     tx_idle_pct;
    int                     rx_idle_pct;
    int                     cycles;
    // timer value the random traffic continues from
    logic [CAP_W-1:0]       timer_now;

    period_window_tracker   tracker;

    period_capture_mean_volume uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // period of 2, high then low
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // watchdog on a cycle count
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // both handshakes sampled at the rising edge, before the block updates
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                tracker.note_event(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready) begin
                tracker.check_reading(m_tdata);
            end
        end
    end

    // result side back-pressure at the current idle rate
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // one input item; valid is left high after the accept so the next item can follow
    task automatic send_event(logic [OP_W-1:0] op, logic [CAP_W-1:0] cap);
        int gap;
        if ($urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                s_tdata  <= S_TDATA_W'($urandom);   // garbage while not valid
                s_tuser  <= OP_W'($urandom);
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= cap;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
    endtask

    // sender goes quiet until every reading due has arrived
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tracker.pending.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        tracker.set_reg(idx, value);
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // all four registers, only ever called with the block idle
    task automatic apply_setting(int unsigned tune, int unsigned num, int unsigned doff, int voff);
        drain_results();
        repeat (4) @(posedge aclk);
        write_reg(REG_TUNED_OFFSET,     CFG_W'(tune));
        write_reg(REG_VOLUME_NUMERATOR, CFG_W'(num));
        write_reg(REG_DIVISOR_OFFSET,   CFG_W'(doff));
        write_reg(REG_VOLUME_OFFSET,    CFG_W'(voff) & CFG_W'(17'h1FFFF));
    endtask

    // mostly whole windows (activate, captures, calculate) with random content,
    // the rest stray items in any order, spare opcode included
    task automatic run_traffic(int n_items);
        int               sent;
        int               length;
        int               base;
        int               period;
        logic             paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 12) begin
                send_event(OP_W'($urandom_range(0, 3)), CAP_W'($urandom));
                sent++;
            end else begin
                // long windows push both sum and count into saturation
                if ($urandom_range(29) == 0) begin
                    length = $urandom_range(150, 180);
                    base   = $urandom_range(58000, 65535);
                end else begin
                    length = $urandom_range(1, 20);
                    case ($urandom_range(3))
                        0:       base = $urandom_range(1, 300);
                        1:       base = $urandom_range(500, PERIOD_SPLIT);
                        2:       base = $urandom_range(PERIOD_SPLIT - 8, PERIOD_SPLIT + 8);
                        default: base = $urandom_range(PERIOD_SPLIT + 1, 65535);
                    endcase
                end
                // now and then a window runs on from the previous capture
                if ($urandom_range(9) != 0) begin
                    timer_now = CAP_W'($urandom);
                    send_event(OP_ACTIVATE, timer_now);
                    sent++;
                end
                for (int i = 0; i < length; i++) begin
                    if ($urandom_range(19) == 0) begin
                        period = 0;               // repeated capture, no period
                    end else begin
                        period = base + $urandom_range(0, 8) - 4;
                    end
                    timer_now = timer_now + CAP_W'(period);
                    send_event(OP_CAPTURE, timer_now);
                end
                send_event(OP_CALCULATE, CAP_W'($urandom));
                sent += length + 1;
            end
            // hold the sender off once per phase until the block has caught up
            if (!paused && sent >= n_items / 2) begin
                drain_results();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        tracker     = new;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        tx_idle_pct = 18;
        rx_idle_pct = 87;
        cycles      = 0;
        timer_now   = '0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: the offset makes short periods negative and long ones positive
        apply_setting(300000, 200_000_000, 1000, -5);
        send_event(OP_SPARE,     16'hFFFF);   // spare opcode straight after reset
        send_event(OP_CALCULATE, 16'h0000);   // empty sum leaves everything held
        send_event(OP_CAPTURE,   16'h0000);   // zero period against the reset capture
        send_event(OP_ACTIVATE,  16'hF000);
        send_event(OP_CAPTURE,   16'hF000);   // zero period after activate
        send_event(OP_CAPTURE,   16'hF3E8);   // 1000: counted, correction negative
        send_event(OP_CAPTURE,   16'h0389);   // 4001 across the wrap: counts twice
        send_event(OP_CAPTURE,   16'h1329);   // 4000 exactly: counts once
        send_event(OP_CAPTURE,   16'h1328);   // 65535: largest period
        send_event(OP_CAPTURE,   16'h1329);   // 1: smallest period
        send_event(OP_CALCULATE, 16'hFFFF);
        send_event(OP_SPARE,     16'h0000);
        send_event(OP_CAPTURE,   16'h6149);   // 20000
        send_event(OP_ACTIVATE,  16'h1234);   // sum kept, count cleared
        send_event(OP_CALCULATE, 16'h5555);   // sum with zero count
        send_event(OP_CALCULATE, 16'hAAAA);   // window already empty
        send_event(OP_ACTIVATE,  16'hFFFF);
        send_event(OP_CAPTURE,   16'h0000);   // 1 across the wrap
        send_event(OP_CAPTURE,   16'h8000);   // 32768
        send_event(OP_SPARE,     16'h7FFF);
        send_event(OP_CALCULATE, 16'h0000);

        // random phases: two extreme settings, then random ones
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph < 3) begin
                tx_idle_pct = 18;
                rx_idle_pct = 87;
            end else if (ph < 6) begin
                tx_idle_pct = 87;
                rx_idle_pct = 18;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (ph)
                0: apply_setting(0, 31'h7FFF_FFFF, 0, -65536);
                1: apply_setting(24'hFF_FFFF, 0, 24'hFF_FFFF, 65535);
                default: begin
                    apply_setting(($urandom_range(3) == 0) ? $urandom_range(0, 24'hFF_FFFF)
                                                           : $urandom_range(0, 400000),
                                  $urandom_range(0, 31'h7FFF_FFFF) >> $urandom_range(0, 14),
                                  $urandom_range(0, 200000),
                                  ($urandom_range(4) == 0) ? $urandom_range(0, 131071) - 65536
                                                           : $urandom_range(0, 4000) - 2000);
                end
            endcase
            run_traffic(PHASE_ITEMS);
        end

        // let the last readings come out, then watch for strays
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
